@@ sv/fragment_reassembly_tracker_macros.svh @@
// assertion macros for the fragment reassembly tracker
`ifndef FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
// implication checked on every edge outside reset
`define FRT_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// next-cycle implication checked on every edge outside reset
`define FRT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

@@ sv/frt_pkg.sv @@
// package: types, constants and codes of the fragment reassembly tracker
package frt_pkg;
   localparam int SLOTS_DEF = 8;
   localparam int MAX_FRAG_DEF = 64;
   localparam logic [15:0] HEADER_BYTES = 16'd14;
   localparam logic [15:0] SOI_PAIR = 16'hFFD8;
   localparam logic [15:0] EOI_PAIR = 16'hFFD9;
   localparam logic [22:0] BYTES_MAX = 23'h7FFFFF;
   localparam logic [15:0] TIMEOUT_RST = 16'd5000;
   localparam logic [22:0] MIN_RST = 23'd1024;
   localparam logic [22:0] MAX_RST = 23'd5242880;

   localparam logic [1:0] REG_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_MIN = 2'd1;
   localparam logic [1:0] REG_MAX = 2'd2;

   typedef enum logic [3:0] {
      ST_STORED = 4'd0, ST_SHORT = 4'd1, ST_BAD_HEADER = 4'd2, ST_DUPLICATE = 4'd3,
      ST_TOO_MANY = 4'd4, ST_TABLE_FULL = 4'd5, ST_VALID = 4'd6, ST_INVALID = 4'd7,
      ST_EXPIRED = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE, FSM_LOOKUP, FSM_DECIDE, FSM_EMIT, FSM_SWEEP, FSM_SWEEP_EMIT
   } fsm_type;

   typedef struct packed {
      logic load;        // capture the input word
      logic lookup;      // register match / free search
      logic commit;      // update the slot and build the result
      logic sweep_check; // free the stale sweep slot and build its expired result
      logic sweep_next;  // advance sweep pointer
      logic out_load;    // result register takes built result
   } cmd_type;

   typedef struct packed {
      logic is_sweep;
      logic sweep_hit;
      logic sweep_done;
      logic sweep_last;
   } stat_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] now_ms;
      logic [15:0] frame_num;
      logic [31:0] frag_total;
      logic [31:0] frag_pos;
      logic [31:0] declared_size;
      logic [15:0] packet_length;
      logic [15:0] head_pair;
      logic [15:0] tail_pair;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] result_frame_id;
      logic [2:0]  slot_index;
      logic [22:0] frame_bytes;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [22:0] data;
   } csr_type;
endpackage

@@ sv/frt_channels.sv @@
// handshake interfaces of the tracker
interface frt_req_if;
   logic valid;
   logic ready;
   frt_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface frt_rsp_if;
   logic valid;
   logic ready;
   frt_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface frt_csr_if;
   logic valid;
   logic ready;
   frt_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/frt_control.sv @@
// controller state machine of the tracker
module frt_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_busy,
   input  frt_pkg::stat_type  stat,
   output frt_pkg::cmd_type   cmd
);
   frt_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frt_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         frt_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = frt_pkg::FSM_LOOKUP;
            end
         end
         frt_pkg::FSM_LOOKUP: begin
            if (stat.is_sweep) begin
               state_in = frt_pkg::FSM_SWEEP;
            end else begin
               cmd.lookup = 1'b1;
               state_in = frt_pkg::FSM_DECIDE;
            end
         end
         frt_pkg::FSM_DECIDE: begin
            if (!rsp_busy) begin
               cmd.commit = 1'b1;
               cmd.out_load = 1'b1;
               state_in = frt_pkg::FSM_IDLE;
            end
         end
         frt_pkg::FSM_SWEEP: begin
            if (stat.sweep_done) begin
               state_in = frt_pkg::FSM_IDLE;
            end else if (stat.sweep_hit) begin
               state_in = frt_pkg::FSM_SWEEP_EMIT;
            end else begin
               cmd.sweep_next = 1'b1;
            end
         end
         frt_pkg::FSM_SWEEP_EMIT: begin
            if (!rsp_busy) begin
               cmd.sweep_check = 1'b1;
               cmd.out_load = 1'b1;
               cmd.sweep_next = 1'b1;
               state_in = stat.sweep_last ? frt_pkg::FSM_IDLE : frt_pkg::FSM_SWEEP;
            end
         end
         default: state_in = frt_pkg::FSM_IDLE;
      endcase
   end
endmodule

@@ sv/frt_datapath.sv @@
// slot table, checks and result register of the tracker
module frt_datapath #(
   parameter int SLOTS = frt_pkg::SLOTS_DEF,
   parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAG_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  frt_pkg::req_type  req_data,
   input  frt_pkg::cmd_type  cmd,
   output frt_pkg::stat_type stat,
   input  logic              csr_write,
   input  frt_pkg::csr_type  csr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output frt_pkg::rsp_type  rsp_data
);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(MAX_FRAGMENTS + 1);
   localparam int FW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

   frt_pkg::req_type  item_ff;
   logic [15:0]       timeout_ff;
   logic [22:0]       min_ff, max_ff;
   logic [SLOTS-1:0]  busy_ff;
   logic [15:0]       frame_ff [SLOTS];
   logic [CW-1:0]     total_ff [SLOTS];
   logic [CW-1:0]     count_ff [SLOTS];
   logic [MAX_FRAGMENTS-1:0] seen_ff [SLOTS];
   logic [31:0]       start_ff [SLOTS];
   logic [22:0]       bytes_ff [SLOTS];
   logic [SLOTS-1:0]  soi_ff, eoi_ff;
   logic              found_ff, free_ok_ff;
   logic [SW-1:0]     found_idx_ff, free_idx_ff;
   logic [SW:0]       sw_ptr_ff;
   logic [3:0]        sw_cnt_ff;
   logic              rsp_valid_ff;
   frt_pkg::rsp_type  rsp_ff;

   // priority search, registered in the lookup step
   logic found_in, free_ok_in;
   logic [SW-1:0] found_idx_in, free_idx_in;
   always_comb begin
      found_in = 1'b0;
      free_ok_in = 1'b0;
      found_idx_in = '0;
      free_idx_in = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (busy_ff[i] && frame_ff[i] == item_ff.frame_num) begin
            found_in = 1'b1;
            found_idx_in = SW'(i);
         end
         if (!busy_ff[i]) begin
            free_ok_in = 1'b1;
            free_idx_in = SW'(i);
         end
      end
   end

   // packet decision
   logic [15:0] plen_m;
   logic short_p, bad_p, bad_slot, too_many, dup, done, ok_frame;
   logic [SW-1:0] s;
   logic [CW-1:0] tot_s, cnt_next;
   logic [FW-1:0] bit_idx;
   logic [23:0]   sum;
   logic [22:0]   bytes_next;
   logic          soi_next, eoi_next;
   frt_pkg::rsp_type built;
   always_comb begin
      plen_m = item_ff.packet_length - frt_pkg::HEADER_BYTES;
      short_p = item_ff.packet_length < frt_pkg::HEADER_BYTES;
      bad_p = (item_ff.frag_pos >= item_ff.frag_total) ||
              (item_ff.declared_size != {16'd0, plen_m});
      s = found_ff ? found_idx_ff : free_idx_ff;
      tot_s = found_ff ? total_ff[s] : CW'(item_ff.frag_total);
      bad_slot = found_ff && (item_ff.frag_pos >= {{(32-CW){1'b0}}, total_ff[s]});
      too_many = !found_ff && (item_ff.frag_total > 32'(MAX_FRAGMENTS));
      bit_idx = item_ff.frag_pos[FW-1:0];
      dup = found_ff && seen_ff[s][bit_idx];
      cnt_next = (found_ff ? count_ff[s] : '0) + CW'(1);
      sum = {1'b0, found_ff ? bytes_ff[s] : 23'd0} + {1'b0, plen_m, 7'd0} / 128;
      bytes_next = sum[23] ? frt_pkg::BYTES_MAX : sum[22:0];
      soi_next = found_ff ? soi_ff[s] : 1'b0;
      eoi_next = found_ff ? eoi_ff[s] : 1'b0;
      if (item_ff.frag_pos == 32'd0)
         soi_next = (plen_m >= 16'd2) && (item_ff.head_pair == frt_pkg::SOI_PAIR);
      if (item_ff.frag_pos == {{(32-CW){1'b0}}, tot_s} - 32'd1)
         eoi_next = (plen_m >= 16'd2) && (item_ff.tail_pair == frt_pkg::EOI_PAIR);
      done = cnt_next == tot_s;
      ok_frame = bytes_next >= 23'd4 && soi_next && eoi_next &&
                 bytes_next >= min_ff && bytes_next <= max_ff;
      built.result_frame_id = item_ff.frame_num;
      built.last = 1'b1;
      built.slot_index = 3'(s);
      built.frame_bytes = found_ff ? bytes_ff[s] : 23'd0;
      if (short_p) begin
         built.status = frt_pkg::ST_SHORT;
         built.slot_index = '0; built.frame_bytes = '0;
      end else if (bad_p) begin
         built.status = frt_pkg::ST_BAD_HEADER;
         built.slot_index = '0; built.frame_bytes = '0;
      end else if (bad_slot) begin
         built.status = frt_pkg::ST_BAD_HEADER;
      end else if (too_many) begin
         built.status = frt_pkg::ST_TOO_MANY;
         built.slot_index = '0;
      end else if (!found_ff && !free_ok_ff) begin
         built.status = frt_pkg::ST_TABLE_FULL;
         built.slot_index = '0;
      end else if (dup) begin
         built.status = frt_pkg::ST_DUPLICATE;
      end else begin
         built.frame_bytes = bytes_next;
         built.status = done ? (ok_frame ? frt_pkg::ST_VALID : frt_pkg::ST_INVALID)
                             : frt_pkg::ST_STORED;
      end
   end
   wire accept_frag = built.status == frt_pkg::ST_STORED ||
                      built.status == frt_pkg::ST_VALID ||
                      built.status == frt_pkg::ST_INVALID;

   // sweep test on the current pointer
   wire [SW-1:0] sp = sw_ptr_ff[SW-1:0];
   wire [31:0] age = item_ff.now_ms - start_ff[sp];
   wire sw_in_range = sw_ptr_ff < (SW+1)'(SLOTS);
   wire sw_hit = sw_in_range && busy_ff[sp] && (age > {16'd0, timeout_ff});
   // the last flag is set when no further stale slot lies above the pointer, or on the eighth expired slot
   logic more;
   always_comb begin
      more = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if ((SW+1)'(i) > sw_ptr_ff && busy_ff[i] &&
             (item_ff.now_ms - start_ff[i]) > {16'd0, timeout_ff}) more = 1'b1;
   end
   assign stat.is_sweep = item_ff.operation;
   assign stat.sweep_hit = sw_hit;
   assign stat.sweep_done = !sw_in_range || sw_cnt_ff == 4'd8;
   assign stat.sweep_last = !more || sw_cnt_ff == 4'd7;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= frt_pkg::TIMEOUT_RST;
         min_ff <= frt_pkg::MIN_RST;
         max_ff <= frt_pkg::MAX_RST;
         busy_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sw_ptr_ff <= '0;
         sw_cnt_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_data.index)
               frt_pkg::REG_TIMEOUT: timeout_ff <= csr_data.data[15:0];
               frt_pkg::REG_MIN: min_ff <= csr_data.data;
               frt_pkg::REG_MAX: max_ff <= csr_data.data;
               default: ;
            endcase
         end
         if (cmd.load) begin
            sw_ptr_ff <= '0;
            sw_cnt_ff <= '0;
         end
         if (cmd.sweep_next) sw_ptr_ff <= sw_ptr_ff + (SW+1)'(1);
         if (cmd.sweep_check) begin
            busy_ff[sp] <= 1'b0;
            sw_cnt_ff <= sw_cnt_ff + 4'd1;
         end
         if (cmd.commit && accept_frag)
            busy_ff[s] <= !done;
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
      if (cmd.lookup) begin
         found_ff <= found_in;
         found_idx_ff <= found_idx_in;
         free_ok_ff <= free_ok_in;
         free_idx_ff <= free_idx_in;
      end
      if (cmd.commit && accept_frag) begin
         frame_ff[s] <= item_ff.frame_num;
         total_ff[s] <= tot_s;
         count_ff[s] <= cnt_next;
         seen_ff[s] <= (found_ff ? seen_ff[s] : '0) | (MAX_FRAGMENTS'(1) << bit_idx);
         if (!found_ff) start_ff[s] <= item_ff.now_ms;
         bytes_ff[s] <= bytes_next;
         soi_ff[s] <= soi_next;
         eoi_ff[s] <= eoi_next;
      end
      if (cmd.commit) rsp_ff <= built;
      if (cmd.sweep_check) begin
         rsp_ff.status <= frt_pkg::ST_EXPIRED;
         rsp_ff.result_frame_id <= frame_ff[sp];
         rsp_ff.slot_index <= 3'(sp);
         rsp_ff.frame_bytes <= bytes_ff[sp];
         rsp_ff.last <= stat.sweep_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

@@ sv/fragment_reassembly_tracker.sv @@
// top level of the fragment reassembly tracker
// channel  | dir | payload
// req      | in  | operation, time, header fields, length, boundary pairs
// rsp      | out | status, frame id, slot, bytes, last
// csr      | in  | register index, data
// a packet: capture, slot search, then decide and update, held while rsp stalls
// a sweep: capture, then visit the slots in order, with an emit step per expired slot
// the single result register holds a stalled word; the block waits on it
// reset clears slot busy bits and loads the register defaults at once
module fragment_reassembly_tracker #(
   parameter int SLOTS = frt_pkg::SLOTS_DEF,
   parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAG_DEF
) (
   input logic clock,
   input logic reset,
   frt_req_if.sink req_bus,
   frt_rsp_if.source rsp_bus,
   frt_csr_if.sink csr_bus
);
`include "fragment_reassembly_tracker_macros.svh"
   frt_pkg::cmd_type cmd;
   frt_pkg::stat_type stat;

   assign csr_bus.ready = 1'b1;

   frt_control u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_bus.valid), .req_ready(req_bus.ready),
      .rsp_busy(rsp_bus.valid && !rsp_bus.ready), .stat(stat), .cmd(cmd)
   );

   frt_datapath #(.SLOTS(SLOTS), .MAX_FRAGMENTS(MAX_FRAGMENTS)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_bus.data), .cmd(cmd), .stat(stat),
      .csr_write(csr_bus.valid && csr_bus.ready), .csr_data(csr_bus.data),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready), .rsp_data(rsp_bus.data)
   );

   `FRT_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !(rsp_bus.valid && !rsp_bus.ready))
   `FRT_ASSERT_NEXT(a_load_valid, clock, reset, cmd.out_load, rsp_bus.valid)
   `FRT_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, !(cmd.commit && cmd.sweep_check))
endmodule

@@ verif/tb_fragment_reassembly_tracker.sv @@
// testbench of the fragment reassembly tracker: queued stimulus, slot table predictor, checker
`timescale 1ns / 100ps

module tb_fragment_reassembly_tracker;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   frt_req_if req_ch ();
   frt_rsp_if rsp_ch ();
   frt_csr_if csr_ch ();

   fragment_reassembly_tracker dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_ch),
      .rsp_bus(rsp_ch),
      .csr_bus(csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predicted slot table and registers
   logic        tbl_busy  [8];
   logic [15:0] tbl_frame [8];
   logic [6:0]  tbl_total [8];
   logic [6:0]  tbl_count [8];
   logic [63:0] tbl_seen  [8];
   logic [31:0] tbl_start [8];
   logic [22:0] tbl_bytes [8];
   logic        tbl_soi   [8];
   logic        tbl_eoi   [8];
   logic [15:0] cfg_timeout;
   logic [22:0] cfg_min;
   logic [22:0] cfg_max;

   frt_pkg::req_type pending_words[$];
   frt_pkg::rsp_type awaited_rsp[$];
   int n_queued = 0;
   int n_taken = 0;
   int mismatches = 0;
   int cycles = 0;
   bit calm = 1'b0;
   logic [31:0] clock_ms;

   function automatic frt_pkg::rsp_type mk_rsp(frt_pkg::status_type st, logic [15:0] fid,
                                               logic [2:0] slot, logic [22:0] bytes);
      frt_pkg::rsp_type r;
      r.status = st;
      r.result_frame_id = fid;
      r.slot_index = slot;
      r.frame_bytes = bytes;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic track_word(frt_pkg::req_type w);
      int s;
      int n;
      frt_pkg::rsp_type r;
      logic [32:0] sum;
      logic ok;
      s = -1;
      n = 0;
      if (w.operation) begin
         // expire stale slots from slot 0 upward
         for (int i = 0; i < 8; i++) begin
            if (tbl_busy[i] && (w.now_ms - tbl_start[i]) > {16'd0, cfg_timeout}) begin
               tbl_busy[i] = 1'b0;
               r = mk_rsp(frt_pkg::ST_EXPIRED, tbl_frame[i], i[2:0], tbl_bytes[i]);
               r.last = 1'b0;
               awaited_rsp.push_back(r);
               n++;
            end
         end
         if (n > 0) awaited_rsp[awaited_rsp.size() - 1].last = 1'b1;
         return;
      end
      if (w.packet_length < frt_pkg::HEADER_BYTES) begin
         awaited_rsp.push_back(mk_rsp(frt_pkg::ST_SHORT, w.frame_num, 3'd0, 23'd0));
         return;
      end
      if (w.frag_pos >= w.frag_total ||
          w.declared_size != ({16'd0, w.packet_length} - 32'd14)) begin
         awaited_rsp.push_back(mk_rsp(frt_pkg::ST_BAD_HEADER, w.frame_num, 3'd0, 23'd0));
         return;
      end
      for (int i = 0; i < 8; i++) begin
         if (s < 0 && tbl_busy[i] && tbl_frame[i] == w.frame_num) s = i;
      end
      if (s >= 0) begin
         if (w.frag_pos >= {25'd0, tbl_total[s]}) begin
            awaited_rsp.push_back(mk_rsp(frt_pkg::ST_BAD_HEADER, w.frame_num, s[2:0],
                                         tbl_bytes[s]));
            return;
         end
      end else begin
         if (w.frag_total > 32'd64) begin
            awaited_rsp.push_back(mk_rsp(frt_pkg::ST_TOO_MANY, w.frame_num, 3'd0, 23'd0));
            return;
         end
         for (int i = 0; i < 8; i++) begin
            if (s < 0 && !tbl_busy[i]) s = i;
         end
         if (s < 0) begin
            awaited_rsp.push_back(mk_rsp(frt_pkg::ST_TABLE_FULL, w.frame_num, 3'd0, 23'd0));
            return;
         end
         tbl_busy[s] = 1'b1;
         tbl_frame[s] = w.frame_num;
         tbl_total[s] = w.frag_total[6:0];
         tbl_count[s] = 7'd0;
         tbl_seen[s] = 64'd0;
         tbl_start[s] = w.now_ms;
         tbl_bytes[s] = 23'd0;
         tbl_soi[s] = 1'b0;
         tbl_eoi[s] = 1'b0;
      end
      if (tbl_seen[s][w.frag_pos[5:0]]) begin
         awaited_rsp.push_back(mk_rsp(frt_pkg::ST_DUPLICATE, w.frame_num, s[2:0],
                                      tbl_bytes[s]));
         return;
      end
      tbl_seen[s][w.frag_pos[5:0]] = 1'b1;
      tbl_count[s] = tbl_count[s] + 7'd1;
      sum = {10'd0, tbl_bytes[s]} + {1'b0, w.declared_size};
      tbl_bytes[s] = (sum > {10'd0, frt_pkg::BYTES_MAX}) ? frt_pkg::BYTES_MAX : sum[22:0];
      if (w.frag_pos == 32'd0)
         tbl_soi[s] = (w.declared_size >= 32'd2 && w.head_pair == frt_pkg::SOI_PAIR);
      if (w.frag_pos == {25'd0, tbl_total[s]} - 32'd1)
         tbl_eoi[s] = (w.declared_size >= 32'd2 && w.tail_pair == frt_pkg::EOI_PAIR);
      if (tbl_count[s] == tbl_total[s]) begin
         ok = tbl_bytes[s] >= 23'd4 && tbl_soi[s] && tbl_eoi[s] &&
              tbl_bytes[s] >= cfg_min && tbl_bytes[s] <= cfg_max;
         tbl_busy[s] = 1'b0;
         awaited_rsp.push_back(mk_rsp(ok ? frt_pkg::ST_VALID : frt_pkg::ST_INVALID,
                                      w.frame_num, s[2:0], tbl_bytes[s]));
         return;
      end
      awaited_rsp.push_back(mk_rsp(frt_pkg::ST_STORED, w.frame_num, s[2:0], tbl_bytes[s]));
   endtask

   // request driver
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            track_word(req_ch.data);
            n_taken++;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the offered word
         end else if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            if (!calm && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 13) - 1;
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid <= 1'b1;
               req_ch.data <= pending_words.pop_front();
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result monitor
   int stall_left = 0;
   always @(posedge clock) begin
      frt_pkg::rsp_type got;
      frt_pkg::rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: expected none, got st %0d fid %h",
                           got.status, got.result_frame_id);
            end else begin
               want = awaited_rsp.pop_front();
               if (got.status !== want.status || got.result_frame_id !== want.result_frame_id ||
                   got.slot_index !== want.slot_index || got.frame_bytes !== want.frame_bytes ||
                   got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected st %0d fid %h slot %0d bytes %0d last %b,",
                               " got st %0d fid %h slot %0d bytes %0d last %b"},
                              want.status, want.result_frame_id, want.slot_index,
                              want.frame_bytes, want.last, got.status, got.result_frame_id,
                              got.slot_index, got.frame_bytes, got.last);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_fragment_reassembly_tracker failed");
         $finish;
      end
   end

   function automatic frt_pkg::req_type mk_frag(logic [15:0] fid, logic [31:0] total,
                                                logic [31:0] idx, logic [15:0] size,
                                                logic [15:0] head, logic [15:0] tail);
      frt_pkg::req_type w;
      w.operation = 1'b0;
      w.now_ms = clock_ms;
      w.frame_num = fid;
      w.frag_total = total;
      w.frag_pos = idx;
      w.declared_size = {16'd0, size};
      w.packet_length = size + 16'd14;
      w.head_pair = head;
      w.tail_pair = tail;
      return w;
   endfunction

   function automatic frt_pkg::req_type mk_sweep();
      frt_pkg::req_type w;
      w = '0;
      w.operation = 1'b1;
      w.now_ms = clock_ms;
      w.frame_num = 16'($urandom);
      w.head_pair = 16'($urandom);
      return w;
   endfunction

   task automatic offer(frt_pkg::req_type w);
      pending_words.push_back(w);
      n_queued++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [22:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data.index <= idx;
      csr_ch.data.data <= val;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
      case (idx)
         frt_pkg::REG_TIMEOUT: cfg_timeout = val[15:0];
         frt_pkg::REG_MIN:     cfg_min = val;
         frt_pkg::REG_MAX:     cfg_max = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      do @(posedge clock); while (n_taken != n_queued || awaited_rsp.size() != 0);
      // a sweep with nothing stale gives no word, let it finish
      repeat (40) @(posedge clock);
   endtask

   task automatic random_part(int count, logic [15:0] id_base);
      int made;
      int tot;
      int order[$];
      frt_pkg::req_type w;
      logic [15:0] fid;
      logic [15:0] sz;
      made = 0;
      while (made < count) begin
         case ($urandom_range(0, 9))
            0: begin
               clock_ms += $urandom_range(0, 3000);
               offer(mk_sweep());
               made++;
            end
            1: begin
               // noise: random header fields
               w.operation = 1'b0;
               w.now_ms = clock_ms;
               w.frame_num = $urandom_range(0, 2) == 0 ? 16'(id_base + $urandom_range(0, 11))
                                                       : 16'($urandom);
               w.frag_total = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 70);
               w.frag_pos = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 70);
               w.packet_length = 16'($urandom);
               w.declared_size = $urandom_range(0, 1) ? $urandom
                                                      : {16'd0, w.packet_length - 16'd14};
               w.head_pair = 16'($urandom);
               w.tail_pair = 16'($urandom);
               offer(w);
               made++;
            end
            default: begin
               fid = 16'(id_base + $urandom_range(0, 11));
               tot = $urandom_range(0, 15) == 0 ? $urandom_range(6, 64) : $urandom_range(1, 4);
               order.delete();
               for (int i = 0; i < tot; i++) order.push_back(i);
               order.shuffle();
               foreach (order[k]) begin
                  if ($urandom_range(0, 9) == 0) continue;
                  clock_ms += $urandom_range(0, 120);
                  sz = $urandom_range(0, 30) == 0 ? 16'($urandom_range(0, 65521))
                                                  : 16'($urandom_range(0, 400));
                  w = mk_frag(fid, 32'(tot), 32'(order[k]), sz,
                              $urandom_range(0, 3) ? frt_pkg::SOI_PAIR : 16'($urandom),
                              $urandom_range(0, 3) ? frt_pkg::EOI_PAIR : 16'($urandom));
                  offer(w);
                  made++;
                  if ($urandom_range(0, 12) == 0) begin
                     offer(w);
                     made++;
                  end
                  if (tot > 8 && made >= count) break;
               end
            end
         endcase
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      for (int i = 0; i < 8; i++) tbl_busy[i] = 1'b0;
      cfg_timeout = frt_pkg::TIMEOUT_RST;
      cfg_min = frt_pkg::MIN_RST;
      cfg_max = frt_pkg::MAX_RST;
      clock_ms = 32'hFFFF_F000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part under reset defaults
      offer(mk_frag(16'h0001, 32'd1, 32'd0, 16'd0, 16'd0, 16'd0));
      pending_words[0].packet_length = 16'd13;
      pending_words[0].declared_size = 32'hFFFF_FFFF;
      offer(mk_frag(16'h0002, 32'd1, 32'd0, 16'd0, 16'd0, 16'd0));
      pending_words[1].packet_length = 16'd0;
      offer(mk_frag(16'h0003, 32'd3, 32'd3, 16'd10, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      offer(mk_frag(16'h0004, 32'd3, 32'd0, 16'd10, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      pending_words[3].declared_size = 32'd11;
      offer(mk_frag(16'h0005, 32'd65, 32'd0, 16'd10, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      offer(mk_frag(16'hFFFF, 32'd1, 32'd0, 16'd2000, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      offer(mk_frag(16'h0000, 32'd1, 32'd0, 16'd3, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      offer(mk_frag(16'h00A0, 32'd2, 32'd0, 16'd0, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      offer(mk_frag(16'h00A0, 32'd2, 32'd0, 16'd0, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      offer(mk_frag(16'h00A0, 32'd5, 32'd2, 16'd8, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      offer(mk_frag(16'h00A0, 32'd2, 32'd1, 16'd1, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      // fill the table, then one frame too many
      for (int i = 0; i < 8; i++) begin
         clock_ms += 32'd100;
         offer(mk_frag(16'h0100 + 16'(i), 32'd64, 32'd63, 16'd65521, 16'h0000,
                       frt_pkg::EOI_PAIR));
      end
      offer(mk_frag(16'h0200, 32'd2, 32'd0, 16'd5, frt_pkg::SOI_PAIR, frt_pkg::EOI_PAIR));
      clock_ms += 32'd4000;
      offer(mk_sweep());
      // time already wrapped past zero before the previous sweep
      clock_ms += 32'd10000;
      offer(mk_sweep());
      drain();

      write_reg(frt_pkg::REG_TIMEOUT, 23'd200);
      write_reg(frt_pkg::REG_MIN, 23'd50);
      write_reg(frt_pkg::REG_MAX, 23'd600);
      random_part(100, 16'($urandom));
      drain();

      write_reg(frt_pkg::REG_TIMEOUT, 23'd0);
      write_reg(frt_pkg::REG_MIN, 23'd0);
      write_reg(frt_pkg::REG_MAX, frt_pkg::BYTES_MAX);
      random_part(50, 16'hFFF4);
      drain();

      write_reg(frt_pkg::REG_TIMEOUT, 23'd65535);
      write_reg(frt_pkg::REG_MIN, frt_pkg::BYTES_MAX);
      write_reg(frt_pkg::REG_MAX, 23'd0);
      random_part(40, 16'h0000);
      drain();

      // last part runs without idling
      calm = 1'b1;
      write_reg(frt_pkg::REG_TIMEOUT, 23'd300);
      write_reg(frt_pkg::REG_MIN, 23'd20);
      write_reg(frt_pkg::REG_MAX, 23'd1000);
      random_part(60, 16'($urandom));
      drain();

      if (awaited_rsp.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("tb_fragment_reassembly_tracker passed");
      end else begin
         $display("tb_fragment_reassembly_tracker failed");
      end
      $finish;
   end
endmodule
